FILE: rtl/shs_pkg.sv
package shs_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;
  localparam int unsigned DigestWords = 8;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LastFill = 6'(BlockBytes - 1);
  localparam logic [5:0] LastRound = 6'(Rounds - 1);
  localparam logic [2:0] LastWord = 3'(DigestWords - 1);

  localparam word_t InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/sha256_stream_hasher_top.sv
// Streaming SHA-256: one message byte per input beat, high end_of_message on the last beat
// (has_byte low on that beat sends no byte, so a lone such beat hashes the empty message).
// A byte that neither fills a block nor ends the message leaves in_ready high. A byte that
// completes a 64-byte block holds in_ready low for the compression, one round per cycle on
// a single shared round unit, and for the fold of the result into the hash state. On the
// last beat the block pads one byte per cycle up to the end of the block (one or two padded
// blocks), compresses each, and then offers the digest as eight 32-bit output beats, word 0
// most significant, last_word high on word 7. in_ready stays low until the eighth word is
// taken, after which the block is back in its initial state.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        has_byte,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import shs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t      state;
  word_t       h [DigestWords];
  word_t       v [8];
  word_t       w [16];
  logic [23:0] acc;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [5:0]  rnd;
  logic [2:0]  oidx;
  logic        eom_pend;
  logic        mark_pend;
  logic        final_blk;
  logic        spill;

  logic        put_en;
  logic [7:0]  put_byte;
  logic [63:0] len_sh;
  logic [7:0]  pad_byte;
  word_t       t1;
  word_t       t2;
  word_t       w_new;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign digest_word = h[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == LastWord);

  // length bytes go out most significant first at block offsets 56..63
  assign len_sh = bits >> {~fill[2:0], 3'b000};

  always_comb begin
    if (mark_pend) begin
      pad_byte = PadMark;
    end else if (fill[5:3] == 3'b111 && !spill) begin
      pad_byte = len_sh[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    put_en   = 1'b0;
    put_byte = data_byte;
    case (state)
      S_IDLE: begin
        put_en = in_valid && has_byte;
      end
      S_PAD: begin
        put_en   = 1'b1;
        put_byte = pad_byte;
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  // shared round unit
  assign t1 = v[7] + big_sigma1(v[4]) + choose(v[4], v[5], v[6]) + round_k(rnd) + w[0];
  assign t2 = big_sigma0(v[0]) + majority(v[0], v[1], v[2]);
  assign w_new = small_sigma1(w[14]) + w[9] + small_sigma0(w[1]) + w[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      bits      <= '0;
      rnd       <= '0;
      oidx      <= '0;
      eom_pend  <= 1'b0;
      mark_pend <= 1'b0;
      final_blk <= 1'b0;
      spill     <= 1'b0;
      for (int i = 0; i < DigestWords; i++) begin
        h[i] <= InitHash[i];
      end
    end else begin
      if (put_en) begin
        fill <= fill + 6'd1;
        acc  <= {acc[15:0], put_byte};
        if (fill[1:0] == 2'b11) begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i + 1];
          end
          w[15] <= {acc, put_byte};
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (has_byte) begin
              bits <= bits + 64'd8;
            end
            if (end_of_message) begin
              eom_pend  <= 1'b1;
              mark_pend <= 1'b1;
            end
            if (has_byte && fill == LastFill) begin
              state <= S_ROUND;
              rnd   <= '0;
              v     <= h;
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          mark_pend <= 1'b0;
          if (fill == LastFill) begin
            final_blk <= !mark_pend && !spill;
            spill     <= 1'b0;
            state     <= S_ROUND;
            rnd       <= '0;
            v         <= h;
          end else if (mark_pend) begin
            // no room left for the length, it goes in one more block
            spill <= (fill[5:3] == 3'b111);
          end
        end
        S_ROUND: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i + 1];
          end
          w[15] <= w_new;
          rnd   <= rnd + 6'd1;
          if (rnd == LastRound) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          for (int i = 0; i < DigestWords; i++) begin
            h[i] <= h[i] + v[i];
          end
          if (final_blk) begin
            state <= S_OUT;
            oidx  <= '0;
          end else if (eom_pend) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == LastWord) begin
              for (int i = 0; i < DigestWords; i++) begin
                h[i] <= InitHash[i];
              end
              bits      <= '0;
              fill      <= '0;
              eom_pend  <= 1'b0;
              final_blk <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/shs_checker.sv
module shs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // no input beat is taken while the digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while digest pending");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=>
      (out_valid && word_index == 3'($past(word_index) + 3'd1)))
    else $error("digest words out of order");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> (!out_valid && in_ready))
    else $error("block not idle after last digest word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(digest_word) && $stable(word_index)))
    else $error("stalled output beat changed");

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last_word   (last_word)
);
